FILE: rtl/core/kei_pkg.sv
// ----------------------------------------------------------------------------
// kei_pkg
// Shared types and fixed-point constants of the keyframe easing interpolator.
// ----------------------------------------------------------------------------
package kei_pkg;

   localparam int FRAC_BITS = 16;
   localparam int NUM_CH    = 6;

   localparam logic [0:0] REQ_WRITE = 1'b0;
   localparam logic [0:0] REQ_EVAL  = 1'b1;

   localparam logic [2:0] EASE_LINEAR   = 3'd0;
   localparam logic [2:0] EASE_QUAD_IN  = 3'd1;
   localparam logic [2:0] EASE_QUAD_OUT = 3'd2;
   localparam logic [2:0] EASE_SMOOTH   = 3'd3;
   localparam logic [2:0] EASE_CUBE_IN  = 3'd4;
   localparam logic [2:0] EASE_CUBE_OUT = 3'd5;
   localparam logic [2:0] EASE_CUBE_IO  = 3'd6;
   localparam logic [2:0] EASE_BOUNCE   = 3'd7;

   typedef logic [NUM_CH-1:0][31:0] kei_chan_type;

   typedef struct packed {
      logic        req_type;
      logic [3:0]  key_index;
      logic [31:0] key_time;
      logic [31:0] in_x;
      logic [31:0] in_y;
      logic [31:0] in_z;
      logic [31:0] in_pitch;
      logic [31:0] in_yaw;
      logic [31:0] in_fov;
      logic [2:0]  easing_code;
      logic [31:0] scene_time;
   } kei_request_type;

   typedef struct packed {
      logic [31:0]          out_x;
      logic [31:0]          out_y;
      logic [31:0]          out_z;
      logic [31:0]          out_pitch;
      logic [31:0]          out_yaw;
      logic [31:0]          out_fov;
      logic [3:0]           segment_index;
      logic [FRAC_BITS:0]   eased_fraction;
   } kei_response_type;

   // Classified work handed from the front end to the back end.
   typedef struct packed {
      logic         is_write;
      logic [3:0]   index;
      logic [31:0]  key_time;
      kei_chan_type chans;
      logic [2:0]   easing;
      logic [31:0]  scene_time;
      logic [4:0]   count;
   } kei_cmd_type;

endpackage

FILE: rtl/core/kei_front.sv
// ----------------------------------------------------------------------------
// kei_front
// Holds the key count register and turns requests into queued commands.
// ----------------------------------------------------------------------------
module kei_front import kei_pkg::*; #(
   parameter int MAX_KEYS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [4:0]      csr_data,
   input  logic            req_push,
   output logic            req_full,
   input  kei_request_type req_payload,
   output logic            enq,
   output kei_cmd_type     enq_cmd,
   input  logic            queue_full
);

   logic [4:0] key_count_ff, key_count_in;
   logic [4:0] count_clip;
   logic       accept;

   assign csr_ready = 1'b1;
   assign req_full  = queue_full;
   assign accept    = req_push && !queue_full;

   always_comb begin
      key_count_in = key_count_ff;
      if (csr_valid) begin
         key_count_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
      end else begin
         key_count_ff <= key_count_in;
      end
   end

   always_comb begin
      if (32'(key_count_ff) > MAX_KEYS) begin
         count_clip = 5'(MAX_KEYS);
      end else begin
         count_clip = key_count_ff;
      end
   end

   always_comb begin
      enq_cmd.is_write   = (req_payload.req_type == REQ_WRITE);
      enq_cmd.index      = req_payload.key_index;
      enq_cmd.key_time   = req_payload.key_time;
      enq_cmd.chans[0]   = req_payload.in_x;
      enq_cmd.chans[1]   = req_payload.in_y;
      enq_cmd.chans[2]   = req_payload.in_z;
      enq_cmd.chans[3]   = req_payload.in_pitch;
      enq_cmd.chans[4]   = req_payload.in_yaw;
      enq_cmd.chans[5]   = req_payload.in_fov;
      enq_cmd.easing     = req_payload.easing_code;
      enq_cmd.scene_time = req_payload.scene_time;
      enq_cmd.count      = count_clip;
   end

   // Writes past the table and evaluations of an empty table are dropped here.
   always_comb begin
      if (enq_cmd.is_write) begin
         enq = accept && (32'(req_payload.key_index) < MAX_KEYS);
      end else begin
         enq = accept && (count_clip != 5'd0);
      end
   end

endmodule

FILE: rtl/core/kei_cmd_fifo.sv
// ----------------------------------------------------------------------------
// kei_cmd_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module kei_cmd_fifo import kei_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        enq,
   input  kei_cmd_type enq_cmd,
   output logic        full,
   input  logic        deq,
   output logic        not_empty,
   output kei_cmd_type head
);

   kei_cmd_type slot_ff [2];
   logic [1:0]  count_ff, count_in;
   logic        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic        do_deq;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_deq    = deq && not_empty;

   always_comb begin
      count_in  = count_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (enq) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (do_deq) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (enq && !do_deq) begin
         count_in = count_ff + 2'd1;
      end else if (!enq && do_deq) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         slot_ff[wr_ptr_ff] <= enq_cmd;
      end
   end

endmodule

FILE: rtl/core/kei_back.sv
// ----------------------------------------------------------------------------
// kei_back
// Keyframe table, segment search, fraction divider, easing and channel lerp.
// ----------------------------------------------------------------------------
module kei_back import kei_pkg::*; #(
   parameter int MAX_KEYS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  kei_cmd_type      cmd,
   output logic             cmd_deq,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output kei_response_type rsp_payload
);

   localparam int IW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int CW  = (IW + 2 > 7) ? IW + 2 : 7;
   localparam int F   = FRAC_BITS;
   localparam int MW  = F + 6;
   localparam int FCW = $clog2(F + 1);
   localparam logic [MW-1:0] ONE   = MW'(1) << F;
   localparam logic [MW-1:0] ONE3  = MW'(3) << F;
   localparam logic [MW-1:0] ONE6  = MW'(6) << F;
   localparam logic [MW-1:0] ONE9  = MW'(9) << F;
   localparam logic [MW-1:0] ONE10 = MW'(10) << F;
   localparam logic [MW-1:0] ONE21 = MW'(21) << F;
   localparam logic [MW-1:0] OFF1  = MW'(3) << (F - 2);
   localparam logic [MW-1:0] OFF2  = MW'(15) << (F - 4);
   localparam logic [MW-1:0] OFF3  = MW'(63) << (F - 6);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SADDR = 9'b000000010,
      ST_SCHK  = 9'b000000100,
      ST_RD    = 9'b000001000,
      ST_SETUP = 9'b000010000,
      ST_DIV   = 9'b000100000,
      ST_EASE1 = 9'b001000000,
      ST_EASE2 = 9'b010000000,
      ST_LERP  = 9'b100000000
   } kei_state_type;

   kei_state_type state_ff, state_in;

   // Keyframe table.
   logic [31:0]  times_mem [MAX_KEYS];
   logic [2:0]   ease_mem  [MAX_KEYS];
   kei_chan_type chan_mem  [MAX_KEYS];

   logic [IW-1:0] rd_a, rd_b;
   logic [31:0]   ta_ff, tb_ff;
   logic [2:0]    code_ff;
   kei_chan_type  pa_ff, pb_ff;

   logic [IW-1:0] i_ff, i_in, a_ff, a_in, b_ff, b_in;
   logic [31:0]   s_ff, s_in;
   logic [4:0]    n_ff, n_in;
   logic [32:0]   rem_ff, rem_in;
   logic [31:0]   den_ff, den_in;
   logic [F:0]    q_ff, q_in;
   logic          tvalid_ff, tvalid_in;
   logic [FCW-1:0] cnt_ff, cnt_in;
   logic [MW-1:0] p1_ff, p1_in, e_ff, e_in;
   logic [2:0]    k_ff, k_in;
   logic signed [50:0] prod_ff, prod_in;
   kei_chan_type  res_ff, res_in;
   kei_response_type out_ff, out_in;
   logic          out_valid_ff, out_valid_in;

   logic          do_write;
   logic [32:0]   rem2;
   logic [MW-1:0] t, u, t11, d, op_b2, p2, fin;
   logic          half;
   logic [2*MW-1:0] prod1, prod2;
   logic signed [32:0] diff;
   logic signed [50:0] qsh;
   logic          out_free;

   assign do_write  = (state_ff == ST_IDLE) && cmd_valid && cmd.is_write;
   assign rd_a      = (state_ff == ST_SADDR) ? i_ff : a_ff;
   assign rd_b      = (state_ff == ST_SADDR) ? i_ff + IW'(1) : b_ff;
   assign out_free  = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (do_write) begin
         times_mem[IW'(cmd.index)] <= cmd.key_time;
         ease_mem[IW'(cmd.index)]  <= cmd.easing;
         chan_mem[IW'(cmd.index)]  <= cmd.chans;
      end
      ta_ff   <= times_mem[rd_a];
      tb_ff   <= times_mem[rd_b];
      code_ff <= ease_mem[rd_a];
      pa_ff   <= chan_mem[rd_a];
      pb_ff   <= chan_mem[rd_b];
   end

   // Easing datapath.
   always_comb begin
      t    = tvalid_ff ? MW'(q_ff) : '0;
      u    = ONE - t;
      half = ((t << 1) < ONE);
      t11  = t * MW'(11);
      if (t11 < (ONE << 2)) begin
         d = t11;
      end else if (t11 < (ONE << 3)) begin
         d = (t11 >= ONE6) ? t11 - ONE6 : ONE6 - t11;
      end else if (t11 < ONE10) begin
         d = (t11 >= ONE9) ? t11 - ONE9 : ONE9 - t11;
      end else begin
         d = ((t11 << 1) >= ONE21) ? (t11 << 1) - ONE21 : ONE21 - (t11 << 1);
      end
      unique case (code_ff)
         EASE_LINEAR:   prod1 = t * ONE;
         EASE_QUAD_OUT: prod1 = t * ((ONE << 1) - t);
         EASE_CUBE_OUT: prod1 = u * u;
         EASE_CUBE_IO:  prod1 = half ? t * t : u * u;
         EASE_BOUNCE:   prod1 = d * d;
         default:       prod1 = t * t;
      endcase
      if (code_ff == EASE_BOUNCE) begin
         if (t11 < (ONE << 2)) begin
            p1_in = MW'(prod1 >> (F + 4));
         end else if (t11 < (ONE << 3)) begin
            p1_in = MW'(prod1 >> (F + 4)) + OFF1;
         end else if (t11 < ONE10) begin
            p1_in = MW'(prod1 >> (F + 4)) + OFF2;
         end else begin
            p1_in = MW'(prod1 >> (F + 6)) + OFF3;
         end
      end else begin
         p1_in = MW'(prod1 >> F);
      end
      unique case (code_ff)
         EASE_SMOOTH:   op_b2 = ONE3 - (t << 1);
         EASE_CUBE_IN:  op_b2 = t;
         EASE_CUBE_OUT: op_b2 = u;
         EASE_CUBE_IO:  op_b2 = half ? t : u;
         default:       op_b2 = ONE;
      endcase
      prod2 = p1_ff * op_b2;
      p2    = MW'(prod2 >> F);
      unique case (code_ff)
         EASE_CUBE_OUT: fin = ONE - p2;
         EASE_CUBE_IO:  fin = half ? (p2 << 2) : ONE - (p2 << 2);
         default:       fin = p2;
      endcase
   end

   // Lerp datapath: one channel product a cycle, added in the cycle after it.
   // The last product is held while the finished result waits for room.
   always_comb begin
      diff    = '0;
      prod_in = prod_ff;
      if (k_ff < 3'(NUM_CH)) begin
         diff = $signed({pb_ff[k_ff][31], pb_ff[k_ff]}) - $signed({pa_ff[k_ff][31], pa_ff[k_ff]});
         prod_in = 51'(diff) * 51'($signed({1'b0, e_ff[F:0]}));
      end
      qsh     = prod_ff >>> F;
      res_in  = res_ff;
      if (k_ff != 3'd0) begin
         res_in[k_ff - 3'd1] = pa_ff[k_ff - 3'd1] + qsh[31:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      s_in      = s_ff;
      n_in      = n_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      q_in      = q_ff;
      tvalid_in = tvalid_ff;
      cnt_in    = cnt_ff;
      e_in      = e_ff;
      k_in      = k_ff;
      cmd_deq   = 1'b0;
      out_in    = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      rem2      = {rem_ff[31:0], 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_deq = 1'b1;
               if (!cmd.is_write) begin
                  s_in = cmd.scene_time;
                  n_in = cmd.count;
                  i_in = '0;
                  a_in = '0;
                  b_in = '0;
                  state_in = (cmd.count > 5'd1) ? ST_SADDR : ST_RD;
               end
            end
         end
         ST_SADDR: state_in = ST_SCHK;
         ST_SCHK: begin
            if (ta_ff <= s_ff && tb_ff > s_ff) begin
               a_in = i_ff;
               b_in = i_ff + IW'(1);
               state_in = ST_RD;
            end else if (CW'(i_ff) + CW'(2) < CW'(n_ff)) begin
               i_in = i_ff + IW'(1);
               state_in = ST_SADDR;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_RD: state_in = ST_SETUP;
         ST_SETUP: begin
            tvalid_in = (tb_ff > ta_ff);
            rem_in    = {1'b0, s_ff - ta_ff};
            den_in    = tb_ff - ta_ff;
            q_in      = '0;
            cnt_in    = FCW'(F);
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            // Restoring division; the partial remainder stays below the divisor when a segment holds the scene time.
            if (rem2 >= {1'b0, den_ff}) begin
               rem_in = rem2 - {1'b0, den_ff};
               q_in   = {q_ff[F-1:0], 1'b1};
            end else begin
               rem_in = rem2;
               q_in   = {q_ff[F-1:0], 1'b0};
            end
            cnt_in = cnt_ff - FCW'(1);
            if (cnt_ff == FCW'(1)) begin
               state_in = ST_EASE1;
            end
         end
         ST_EASE1: state_in = ST_EASE2;
         ST_EASE2: begin
            e_in     = (fin > ONE) ? ONE : fin;
            k_in     = '0;
            state_in = ST_LERP;
         end
         ST_LERP: begin
            if (k_ff == 3'(NUM_CH)) begin
               if (out_free) begin
                  out_in.out_x          = res_in[0];
                  out_in.out_y          = res_in[1];
                  out_in.out_z          = res_in[2];
                  out_in.out_pitch      = res_in[3];
                  out_in.out_yaw        = res_in[4];
                  out_in.out_fov        = res_in[5];
                  out_in.segment_index  = 4'(a_ff);
                  out_in.eased_fraction = (F + 1)'(e_ff);
                  out_valid_in          = 1'b1;
                  state_in              = ST_IDLE;
               end
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      s_ff      <= s_in;
      n_ff      <= n_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      q_ff      <= q_in;
      tvalid_ff <= tvalid_in;
      cnt_ff    <= cnt_in;
      p1_ff     <= p1_in;
      e_ff      <= e_in;
      k_ff      <= k_in;
      prod_ff   <= prod_in;
      res_ff    <= res_in;
      out_ff    <= out_in;
   end

endmodule

FILE: rtl/core/keyframe_easing_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_easing_interpolator
// Camera keyframe table with segment search, easing and channel interpolation.
// ----------------------------------------------------------------------------
// A keyframe write is stored in the table by the idle back end and gives no
// result. For an evaluation the segment search reads two key times per step
// from the table memory, the fraction comes from a restoring divider that
// yields one bit a cycle, the easing takes two multiply stages, and the six
// channels share one lerp multiplier. A two-entry queue lets requests arrive
// while the back end works, and a finished result waits in an output
// register; the back end only stalls when its next result is ready before
// that one has been taken.
module keyframe_easing_interpolator import kei_pkg::*; #(
   parameter int MAX_KEYS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [4:0]       csr_data,
   input  logic             req_push,
   output logic             req_full,
   input  kei_request_type  req_payload,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output kei_response_type rsp_payload
);

   logic        enq, queue_full, cmd_valid, cmd_deq;
   kei_cmd_type enq_cmd, head;

   kei_front #(.MAX_KEYS(MAX_KEYS)) u_front (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_push(req_push), .req_full(req_full), .req_payload(req_payload),
      .enq(enq), .enq_cmd(enq_cmd), .queue_full(queue_full)
   );

   kei_cmd_fifo u_fifo (
      .clock(clock), .reset(reset),
      .enq(enq), .enq_cmd(enq_cmd), .full(queue_full),
      .deq(cmd_deq), .not_empty(cmd_valid), .head(head)
   );

   kei_back #(.MAX_KEYS(MAX_KEYS)) u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd(head), .cmd_deq(cmd_deq),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_payload(rsp_payload)
   );

endmodule

FILE: rtl/core/kei_checker.sv
// ----------------------------------------------------------------------------
// kei_checker
// Port-level checks of the keyframe easing interpolator.
// ----------------------------------------------------------------------------
module kei_port_checks import kei_pkg::*; #(
   parameter int MAX_KEYS = 16
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input kei_response_type rsp_payload
);

   localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS + 1)'(1) << FRAC_BITS;

   // No result can be waiting right after reset.
   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_payload))
      else $error("waiting result changed");

   a_fraction_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_payload.eased_fraction <= ONE_Q)
      else $error("eased fraction above one");

   a_segment_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> 32'(rsp_payload.segment_index) < MAX_KEYS)
      else $error("segment index beyond table");

endmodule

bind keyframe_easing_interpolator kei_port_checks #(.MAX_KEYS(MAX_KEYS)) u_kei_checker (
   .clock(clock), .reset(reset), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
   .rsp_payload(rsp_payload)
);
